@@ hw/rtl/utf8_latin_fold_to_ascii_core_assert.svh @@
// assertion macros for the latin fold core
`ifndef UTF8_LATIN_FOLD_TO_ASCII_CORE_ASSERT_SVH
`define UTF8_LATIN_FOLD_TO_ASCII_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ULFA_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ULFA_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("next-cycle check failed");

`endif

@@ hw/rtl/ulfa_pkg.sv @@
// types, constants and fold tables shared by the latin fold core
`default_nettype none

package ulfa_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] LEAD_C2      = 8'hC2;
   localparam logic [7:0] LEAD_C3      = 8'hC3;
   localparam logic [7:0] LEAD_C4      = 8'hC4;
   localparam logic [7:0] LEAD_C5      = 8'hC5;
   localparam logic [7:0] UPPER_FIRST  = 8'h41;
   localparam logic [7:0] UPPER_LAST   = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'd32;

   localparam logic [1:0] PAGE_NONE = 2'd0;
   localparam logic [1:0] PAGE_C3   = 2'd1;
   localparam logic [1:0] PAGE_C4   = 2'd2;
   localparam logic [1:0] PAGE_C5   = 2'd3;

   localparam logic [1:0] SKIP_NONE  = 2'd0;
   localparam logic [1:0] SKIP_TWO   = 2'd1;
   localparam logic [1:0] SKIP_THREE = 2'd2;
   localparam logic [1:0] SKIP_FOUR  = 2'd3;

   localparam logic [2:0] ADDR_STRIP_MODE = 3'd0;

   // up to two characters from the fold table
   typedef struct packed {
      logic [1:0] count;
      logic [6:0] c0;
      logic [6:0] c1;
   } ulfa_rom_type;

   // one queued work entry: characters plus string-end flag
   typedef struct packed {
      logic [1:0] count;
      logic [6:0] c0;
      logic [6:0] c1;
      logic       last;
   } ulfa_entry_type;

   // decoder state seen from outside
   typedef struct packed {
      logic [1:0] pending_page;
      logic [1:0] skip_remaining;
   } ulfa_front_status_type;

   function automatic ulfa_rom_type rom_none();
      ulfa_rom_type r;
      r.count = 2'd0;
      r.c0    = 7'd0;
      r.c1    = 7'd0;
      return r;
   endfunction

   function automatic ulfa_rom_type rom_one(input logic [7:0] a);
      ulfa_rom_type r;
      r.count = 2'd1;
      r.c0    = a[6:0];
      r.c1    = 7'd0;
      return r;
   endfunction

   function automatic ulfa_rom_type rom_two(input logic [7:0] a, input logic [7:0] b);
      ulfa_rom_type r;
      r.count = 2'd2;
      r.c0    = a[6:0];
      r.c1    = b[6:0];
      return r;
   endfunction

   // page c3: both halves match except the last entry
   function automatic ulfa_rom_type rom_c3(input logic [5:0] idx, input logic strip);
      ulfa_rom_type r;
      if (idx == 6'd63) begin
         r = rom_one("y");
      end else begin
         unique case (idx[4:0])
            5'd0, 5'd1, 5'd2, 5'd3, 5'd5: r = rom_one("a");
            5'd4:  r = strip ? rom_one("a") : rom_two("a", "e");
            5'd6:  r = rom_two("a", "e");
            5'd7:  r = rom_one("c");
            5'd8, 5'd9, 5'd10, 5'd11:     r = rom_one("e");
            5'd12, 5'd13, 5'd14, 5'd15:   r = rom_one("i");
            5'd16: r = rom_one("d");
            5'd17: r = rom_one("n");
            5'd18, 5'd19, 5'd20, 5'd21:   r = rom_one("o");
            5'd22: r = strip ? rom_one("o") : rom_two("o", "e");
            5'd23: r = rom_none();
            5'd24: r = rom_one("o");
            5'd25, 5'd26, 5'd27:          r = rom_one("u");
            5'd28: r = strip ? rom_one("u") : rom_two("u", "e");
            5'd29: r = rom_one("y");
            5'd30: r = rom_two("t", "h");
            5'd31: r = strip ? rom_one("s") : rom_two("s", "s");
         endcase
      end
      return r;
   endfunction

   function automatic ulfa_rom_type rom_c4(input logic [5:0] idx);
      ulfa_rom_type r;
      priority if (idx < 6'd6)  r = rom_one("a");
      else if (idx < 6'd14)     r = rom_one("c");
      else if (idx < 6'd18)     r = rom_one("d");
      else if (idx < 6'd28)     r = rom_one("e");
      else if (idx < 6'd36)     r = rom_one("g");
      else if (idx < 6'd40)     r = rom_one("h");
      else if (idx < 6'd50)     r = rom_one("i");
      else if (idx < 6'd52)     r = rom_two("i", "j");
      else if (idx < 6'd54)     r = rom_one("j");
      else if (idx < 6'd57)     r = rom_one("k");
      else                      r = rom_one("l");
      return r;
   endfunction

   function automatic ulfa_rom_type rom_c5(input logic [5:0] idx);
      ulfa_rom_type r;
      priority if (idx < 6'd3)  r = rom_one("l");
      else if (idx < 6'd12)     r = rom_one("n");
      else if (idx < 6'd18)     r = rom_one("o");
      else if (idx < 6'd20)     r = rom_two("o", "e");
      else if (idx < 6'd26)     r = rom_one("r");
      else if (idx < 6'd34)     r = rom_one("s");
      else if (idx < 6'd40)     r = rom_one("t");
      else if (idx < 6'd52)     r = rom_one("u");
      else if (idx < 6'd54)     r = rom_one("w");
      else if (idx < 6'd57)     r = rom_one("y");
      else if (idx < 6'd63)     r = rom_one("z");
      else                      r = rom_one("s");
      return r;
   endfunction

   function automatic ulfa_rom_type rom_lookup(input logic [1:0] page,
                                               input logic [5:0] idx,
                                               input logic       strip);
      ulfa_rom_type r;
      unique case (page)
         PAGE_C3:   r = rom_c3(idx, strip);
         PAGE_C4:   r = rom_c4(idx);
         PAGE_C5:   r = rom_c5(idx);
         default:   r = rom_none();
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ulfa_front.sv @@
// front end: takes input beats, tracks the utf-8 sequence state, looks up folds
`default_nettype none

module ulfa_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           strip_mode,
   input  wire logic                           req_valid,
   input  wire logic [7:0]                     req_in_byte,
   input  wire logic                           req_last_in_string,
   output logic                                req_stall,
   input  wire logic                           q_space,
   output logic                                q_push,
   output ulfa_pkg::ulfa_entry_type            q_entry,
   output ulfa_pkg::ulfa_front_status_type     status
);

   logic [1:0] page_ff, page_in;
   logic [1:0] skip_ff, skip_in;
   logic       fire;
   ulfa_pkg::ulfa_rom_type rom;
   ulfa_pkg::ulfa_rom_type chars;

   assign req_stall = !q_space;
   assign fire      = req_valid && q_space;

   assign rom = ulfa_pkg::rom_lookup(page_ff, req_in_byte[5:0], strip_mode);

   always_comb begin
      page_in = page_ff;
      skip_in = skip_ff;
      chars   = ulfa_pkg::rom_none();
      priority if (skip_ff != ulfa_pkg::SKIP_NONE) begin
         skip_in = skip_ff - 2'd1;
      end else if (page_ff != ulfa_pkg::PAGE_NONE) begin
         if (req_in_byte[7:6] == 2'b10) begin
            chars = rom;
         end
         page_in = ulfa_pkg::PAGE_NONE;
      end else if (!req_in_byte[7]) begin
         if (req_in_byte >= ulfa_pkg::UPPER_FIRST && req_in_byte <= ulfa_pkg::UPPER_LAST) begin
            chars = ulfa_pkg::rom_one(req_in_byte + ulfa_pkg::CASE_OFFSET);
         end else begin
            chars = ulfa_pkg::rom_one(req_in_byte);
         end
      end else if (req_in_byte == ulfa_pkg::LEAD_C3 || req_in_byte == ulfa_pkg::LEAD_C4 ||
                   req_in_byte == ulfa_pkg::LEAD_C5) begin
         page_in = 2'(req_in_byte - ulfa_pkg::LEAD_C2);
      end else if (req_in_byte[7:5] == 3'b110) begin
         skip_in = ulfa_pkg::SKIP_TWO;
      end else if (req_in_byte[7:4] == 4'b1110) begin
         skip_in = ulfa_pkg::SKIP_THREE;
      end else if (req_in_byte[7:3] == 5'b11110) begin
         skip_in = ulfa_pkg::SKIP_FOUR;
      end else begin
         // stray continuation and f8..ff: dropped alone
         skip_in = skip_ff;
      end
      if (req_last_in_string) begin
         page_in = ulfa_pkg::PAGE_NONE;
         skip_in = ulfa_pkg::SKIP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= ulfa_pkg::PAGE_NONE;
         skip_ff <= ulfa_pkg::SKIP_NONE;
      end else if (fire) begin
         page_ff <= page_in;
         skip_ff <= skip_in;
      end
   end

   // beats that make no character and do not end a string are not queued
   assign q_entry.count = chars.count;
   assign q_entry.c0    = chars.c0;
   assign q_entry.c1    = chars.c1;
   assign q_entry.last  = req_last_in_string;
   assign q_push        = fire && (chars.count != 2'd0 || req_last_in_string);

   assign status.pending_page   = page_ff;
   assign status.skip_remaining = skip_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ulfa_queue.sv @@
// short entry queue between front and back end
`default_nettype none

module ulfa_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  ulfa_pkg::ulfa_entry_type    push_entry,
   input  wire logic                   pop,
   output ulfa_pkg::ulfa_entry_type    head_entry,
   output logic                        head_valid,
   output logic                        full
);

   localparam int DEPTH = ulfa_pkg::QUEUE_DEPTH;
   localparam int PW    = ulfa_pkg::QPTR_W;
   localparam int CW    = ulfa_pkg::QCNT_W;

   ulfa_pkg::ulfa_entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign head_entry = slot_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CW'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ulfa_back.sv @@
// back end: walks each queued entry and drives the result register
`default_nettype none

module ulfa_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  ulfa_pkg::ulfa_entry_type    head_entry,
   input  wire logic                   head_valid,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [6:0]                  rsp_out_char,
   output logic                        rsp_char_valid,
   output logic                        rsp_run_last,
   output logic                        rsp_string_end
);

   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       cvalid_ff, cvalid_in;
   logic       run_last_ff, run_last_in;
   logic       end_ff, end_in;
   logic [1:0] sub_ff, sub_in;
   logic [1:0] total;
   logic       load;
   logic       final_beat;

   assign total      = head_entry.count + {1'b0, head_entry.last};
   assign load       = head_valid && (!valid_ff || !rsp_stall);
   assign final_beat = (sub_ff == total - 2'd1);
   assign pop        = load && final_beat;

   always_comb begin
      valid_in    = valid_ff && rsp_stall;
      sub_in      = sub_ff;
      char_in     = char_ff;
      cvalid_in   = cvalid_ff;
      run_last_in = run_last_ff;
      end_in      = end_ff;
      if (load) begin
         valid_in = 1'b1;
         sub_in   = final_beat ? 2'd0 : sub_ff + 2'd1;
         if (sub_ff < head_entry.count) begin
            char_in     = (sub_ff == 2'd0) ? head_entry.c0 : head_entry.c1;
            cvalid_in   = 1'b1;
            run_last_in = !head_entry.last && (sub_ff == head_entry.count - 2'd1);
            end_in      = 1'b0;
         end else begin
            // string terminator
            char_in     = 7'd0;
            cvalid_in   = 1'b0;
            run_last_in = 1'b1;
            end_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      cvalid_ff   <= cvalid_in;
      run_last_ff <= run_last_in;
      end_ff      <= end_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_char_valid = cvalid_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_string_end = end_ff;

endmodule

`default_nettype wire

@@ hw/rtl/utf8_latin_fold_to_ascii_core.sv @@
// top level of the utf-8 latin fold to lower-case ascii core
`default_nettype none

`include "utf8_latin_fold_to_ascii_core_assert.svh"

// utf-8 latin fold core: one input beat is one byte of a utf-8 string; result
// beats are lower-case ascii characters, plus a terminator beat after the byte
// flagged last_in_string. bytes below 0x80 pass (upper case lowered), lead
// bytes c3/c4/c5 fold the following continuation byte through a fixed table
// into zero to two characters, other sequences are dropped by their length code.
// rate: a byte is taken every cycle as long as each byte makes at most one
// result beat and rsp_stall is low; a byte that makes more result beats holds
// the back end until they are out, and a two-entry queue between the decoder
// and the result sequencer soaks up the difference, so the input stalls only
// once that queue is full. bytes pass the queue and then a result register.
// strip_mode (address 0) selects plain stripping of the german umlauts and
// sharp s when set, the two-letter expansion when clear; write it only while idle.
module utf8_latin_fold_to_ascii_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // input channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_last_in_string,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [6:0]       rsp_out_char,
   output logic             rsp_char_valid,
   output logic             rsp_run_last,
   output logic             rsp_string_end,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic strip_ff, strip_in;
   logic cfg_write;

   logic                               q_push;
   logic                               q_pop;
   logic                               q_full;
   logic                               q_head_valid;
   ulfa_pkg::ulfa_entry_type           q_entry;
   ulfa_pkg::ulfa_entry_type           q_head;
   ulfa_pkg::ulfa_front_status_type    front_status;

   // register file: only strip_mode lives here
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == ulfa_pkg::ADDR_STRIP_MODE);
   assign strip_in   = cfg_write ? csr_pwdata[0] : strip_ff;
   assign csr_prdata = (csr_paddr == ulfa_pkg::ADDR_STRIP_MODE) ? {31'd0, strip_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff <= 1'b0;
      end else begin
         strip_ff <= strip_in;
      end
   end

   // decoder: state tracking and table lookup, one byte a cycle while the queue has room
   ulfa_front u_front (
      .clock              (clock),
      .reset              (reset),
      .strip_mode         (strip_ff),
      .req_valid          (req_valid),
      .req_in_byte        (req_in_byte),
      .req_last_in_string (req_last_in_string),
      .req_stall          (req_stall),
      .q_space            (!q_full || q_pop),
      .q_push             (q_push),
      .q_entry            (q_entry),
      .status             (front_status)
   );

   // decouples the decoder from the result sequencer
   ulfa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head_entry (q_head),
      .head_valid (q_head_valid),
      .full       (q_full)
   );

   // emits one result beat per cycle from the queue head unless rsp_stall holds it
   ulfa_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (q_head),
      .head_valid     (q_head_valid),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   // no beat is accepted into a full queue that is not draining
   `ULFA_ASSERT_IMPLY(a_no_overflow, clock, reset, q_push, !q_full || q_pop)
   // a last byte leaves the decoder with nothing held or skipped
   `ULFA_ASSERT_NEXT(a_end_clears_state, clock, reset,
      req_valid && !req_stall && req_last_in_string,
      front_status.pending_page == ulfa_pkg::PAGE_NONE &&
      front_status.skip_remaining == ulfa_pkg::SKIP_NONE)
   // the terminator carries no character and closes the run
   `ULFA_ASSERT_IMPLY(a_terminator_shape, clock, reset, rsp_valid && rsp_string_end,
      rsp_run_last && !rsp_char_valid && rsp_out_char == 7'd0)
   // a character beat never closes a string
   `ULFA_ASSERT_IMPLY(a_char_not_end, clock, reset, rsp_valid && rsp_char_valid,
      !rsp_string_end)

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// self-checking testbench for the utf-8 latin fold core, random and directed byte streams
`default_nettype none

module tb;

   // run limits and pacing
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 64;
   localparam int REPORT_MAX   = 10;
   localparam int PHASE_BYTES  = 120;

   // fold tables, one character per table entry, entry 0 in the leftmost byte
   // an underscore marks an entry that contributes no character
   localparam logic [7:0] NO_CHAR = "_";
   localparam logic [511:0] C3_HEAD = {
      "aaaaaaac", "eeeeiiii", "dnooooo_", "ouuuuyts",
      "aaaaaaac", "eeeeiiii", "dnooooo_", "ouuuuyty"};
   // two-letter umlaut and sharp s expansion, plus the ae ligature and thorn
   localparam logic [511:0] C3_DIN_TAIL = {
      "____e_e_", "________", "______e_", "____e_hs",
      "____e_e_", "________", "______e_", "____e_h_"};
   // plain stripping keeps only the ae ligature and thorn
   localparam logic [511:0] C3_STRIP_TAIL = {
      "______e_", "________", "________", "______h_",
      "______e_", "________", "________", "______h_"};
   localparam logic [511:0] C4_HEAD = {
      "aaaaaacc", "ccccccdd", "ddeeeeee", "eeeegggg",
      "gggghhhh", "iiiiiiii", "iiiijjkk", "klllllll"};
   localparam logic [511:0] C4_TAIL = {
      "________", "________", "________", "________",
      "________", "________", "__jj____", "________"};
   localparam logic [511:0] C5_HEAD = {
      "lllnnnnn", "nnnnoooo", "oooorrrr", "rrssssss",
      "sstttttt", "uuuuuuuu", "uuuuwwyy", "yzzzzzzs"};
   localparam logic [511:0] C5_TAIL = {
      "________", "________", "__ee____", "________",
      "________", "________", "________", "________"};

   // one input beat: a byte of the utf-8 text and its end-of-string flag
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_byte_type;

   // one result beat as it appears on the rsp_ ports
   typedef struct packed {
      logic [6:0] ch;
      logic       char_valid;
      logic       run_last;
      logic       string_end;
   } fold_beat_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // input channel
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte        = 8'd0;
   logic        req_last_in_string = 1'b0;

   // result channel
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_out_char;
   logic        rsp_char_valid;
   logic        rsp_run_last;
   logic        rsp_string_end;

   // configuration port
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = 3'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // bytes waiting to be offered, and folded beats waiting to come out
   text_byte_type byte_feed [$];
   fold_beat_type fold_expect [$];

   // predictor state and its copy of strip_mode
   logic [1:0] held_page = ulfa_pkg::PAGE_NONE;
   logic [1:0] drop_left = ulfa_pkg::SKIP_NONE;
   logic       strip_sel = 1'b0;

   // pacing knobs, percent of cycles spent idle on each side
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long receiver hold-offs, asked for by the stimulus and served by the receiver
   int holds_asked = 0;
   int holds_done  = 0;
   int hold_left   = 0;

   // bookkeeping
   int fail_count  = 0;
   int bytes_taken = 0;
   int beats_seen  = 0;
   int cycle_count = 0;

   utf8_latin_fold_to_ascii_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_last_in_string (req_last_in_string),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_char       (rsp_out_char),
      .rsp_char_valid     (rsp_char_valid),
      .rsp_run_last       (rsp_run_last),
      .rsp_string_end     (rsp_string_end),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #2 clock = ~clock;

   // table entry idx of a 64-entry fold table
   function automatic logic [7:0] table_char(input logic [511:0] tbl, input logic [5:0] idx);
      return tbl[8 * (63 - int'(idx)) +: 8];
   endfunction

   // random byte in lo..hi
   function automatic logic [7:0] rand_byte(input int lo, input int hi);
      logic [31:0] r;
      r = $urandom_range(hi, lo);
      return r[7:0];
   endfunction

   // fold one accepted byte and queue the result beats it must cause
   task automatic fold_byte(input logic [7:0] b, input logic last);
      logic [7:0] head;
      logic [7:0] tail;
      logic [6:0] chars [2];
      fold_beat_type beat;
      int n;
      n    = 0;
      head = NO_CHAR;
      tail = NO_CHAR;
      if (drop_left != ulfa_pkg::SKIP_NONE) begin
         // inside a dropped sequence, content does not matter
         drop_left = drop_left - 2'd1;
      end else if (held_page != ulfa_pkg::PAGE_NONE) begin
         // second byte of a latin sequence, only continuation bytes fold
         if (b[7:6] == 2'b10) begin
            case (held_page)
               ulfa_pkg::PAGE_C3: begin
                  head = table_char(C3_HEAD, b[5:0]);
                  tail = table_char(strip_sel ? C3_STRIP_TAIL : C3_DIN_TAIL, b[5:0]);
               end
               ulfa_pkg::PAGE_C4: begin
                  head = table_char(C4_HEAD, b[5:0]);
                  tail = table_char(C4_TAIL, b[5:0]);
               end
               default: begin
                  head = table_char(C5_HEAD, b[5:0]);
                  tail = table_char(C5_TAIL, b[5:0]);
               end
            endcase
            if (head != NO_CHAR) begin
               chars[n] = head[6:0];
               n++;
            end
            if (tail != NO_CHAR) begin
               chars[n] = tail[6:0];
               n++;
            end
         end
         held_page = ulfa_pkg::PAGE_NONE;
      end else if (b < 8'h80) begin
         // plain ascii, upper case lowered
         if (b >= ulfa_pkg::UPPER_FIRST && b <= ulfa_pkg::UPPER_LAST)
            chars[0] = 7'(b + ulfa_pkg::CASE_OFFSET);
         else chars[0] = b[6:0];
         n = 1;
      end else if (b == ulfa_pkg::LEAD_C3) begin
         held_page = ulfa_pkg::PAGE_C3;
      end else if (b == ulfa_pkg::LEAD_C4) begin
         held_page = ulfa_pkg::PAGE_C4;
      end else if (b == ulfa_pkg::LEAD_C5) begin
         held_page = ulfa_pkg::PAGE_C5;
      end else if ((b & 8'hE0) == 8'hC0) begin
         drop_left = ulfa_pkg::SKIP_TWO;
      end else if ((b & 8'hF0) == 8'hE0) begin
         drop_left = ulfa_pkg::SKIP_THREE;
      end else if ((b & 8'hF8) == 8'hF0) begin
         drop_left = ulfa_pkg::SKIP_FOUR;
      end
      // stray continuation bytes and f8..ff simply vanish
      for (int k = 0; k < n; k++) begin
         beat.ch         = chars[k];
         beat.char_valid = 1'b1;
         beat.run_last   = (!last && k == n - 1);
         beat.string_end = 1'b0;
         fold_expect = {fold_expect, beat};
      end
      // end of string drops any half-done sequence and adds a terminator beat
      if (last) begin
         held_page       = ulfa_pkg::PAGE_NONE;
         drop_left       = ulfa_pkg::SKIP_NONE;
         beat.ch         = 7'd0;
         beat.char_valid = 1'b0;
         beat.run_last   = 1'b1;
         beat.string_end = 1'b1;
         fold_expect = {fold_expect, beat};
      end
   endtask

   // sender: a new byte goes out whenever the current beat is taken or none is up
   always @(posedge clock) begin : drive_bytes
      text_byte_type nxt;
      if (reset) begin
         req_valid          <= 1'b0;
         req_in_byte        <= 8'd0;
         req_last_in_string <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = byte_feed.pop_front();
            req_valid          <= 1'b1;
            req_in_byte        <= nxt.data;
            req_last_in_string <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         // the hold-off counts its own cycles, the sender keeps offering meanwhile
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_CYCLES - 1;
         holds_done <= holds_done + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor: check each taken result beat first, then predict from each taken input beat
   always @(posedge clock) begin : check_beats
      fold_beat_type got;
      fold_beat_type want;
      if (reset) begin
         held_page = ulfa_pkg::PAGE_NONE;
         drop_left = ulfa_pkg::SKIP_NONE;
         fold_expect.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_char, rsp_char_valid, rsp_run_last, rsp_string_end};
            beats_seen++;
            if (fold_expect.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected result beat %0d: char %h valid %b last %b end %b",
                           beats_seen, got.ch, got.char_valid, got.run_last, got.string_end);
            end else begin
               want = fold_expect.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX)
                     $display("beat %0d: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                              beats_seen, want.ch, want.char_valid, want.run_last,
                              want.string_end, got.ch, got.char_valid, got.run_last,
                              got.string_end);
               end
            end
         end
         if (req_valid && !req_stall) begin
            bytes_taken++;
            fold_byte(req_in_byte, req_last_in_string);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("utf8_latin_fold_to_ascii_core regression: fail");
         $finish;
      end
   end

   // apb write: setup cycle, then access cycle, register taken at the access edge
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // apb read, data sampled at the access edge
   task automatic csr_read(input logic [2:0] addr, output logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write strip_mode, track it in the predictor and read it back
   task automatic set_strip_mode(input logic mode);
      logic [31:0] rd;
      csr_write(ulfa_pkg::ADDR_STRIP_MODE, {31'd0, mode});
      strip_sel = mode;
      csr_read(ulfa_pkg::ADDR_STRIP_MODE, rd);
      if (rd !== {31'd0, mode}) begin
         fail_count++;
         if (fail_count <= REPORT_MAX)
            $display("strip_mode readback: expected %h, got %h", {31'd0, mode}, rd);
      end
   endtask

   task automatic push_byte(input logic [7:0] data, input logic last);
      text_byte_type tb_byte;
      tb_byte.data = data;
      tb_byte.last = last;
      byte_feed = {byte_feed, tb_byte};
   endtask

   // wait until every byte is taken and every beat is out, then let the pipe settle
   task automatic wait_drained;
      while (byte_feed.size() != 0 || req_valid || fold_expect.size() != 0 ||
             holds_done != holds_asked || hold_left != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random text, mostly well-formed latin and ascii with some junk and broken sequences
   task automatic queue_random_text(input int nbytes);
      logic [7:0] tok [$];
      logic [7:0] lead;
      int pick;
      int total;
      total = 0;
      while (total < nbytes) begin
         tok.delete();
         pick = $urandom_range(99);
         if (pick < 40) begin
            tok = {tok, rand_byte(0, 127)};
         end else if (pick < 70) begin
            // well-formed latin pair
            tok = {tok, 8'(ulfa_pkg::LEAD_C3 + rand_byte(0, 2))};
            tok = {tok, rand_byte(8'h80, 8'hBF)};
         end else if (pick < 76) begin
            // latin lead with a bad second byte
            tok = {tok, 8'(ulfa_pkg::LEAD_C3 + rand_byte(0, 2))};
            if ($urandom_range(1)) tok = {tok, rand_byte(0, 127)};
            else tok = {tok, rand_byte(8'hC0, 8'hFF)};
         end else if (pick < 83) begin
            // other two-byte sequence, dropped whole
            do lead = rand_byte(8'hC0, 8'hDF);
            while (lead == ulfa_pkg::LEAD_C3 || lead == ulfa_pkg::LEAD_C4 ||
                   lead == ulfa_pkg::LEAD_C5);
            tok = {tok, lead};
            tok = {tok, rand_byte(0, 255)};
         end else if (pick < 89) begin
            tok = {tok, rand_byte(8'hE0, 8'hEF)};
            repeat (2) tok = {tok, rand_byte(0, 255)};
         end else if (pick < 95) begin
            tok = {tok, rand_byte(8'hF0, 8'hF7)};
            repeat (3) tok = {tok, rand_byte(0, 255)};
         end else begin
            // stray continuation or invalid lead
            if ($urandom_range(1)) tok = {tok, rand_byte(8'h80, 8'hBF)};
            else tok = {tok, rand_byte(8'hF8, 8'hFF)};
         end
         // strings mostly end on a sequence boundary, sometimes in the middle
         foreach (tok[i]) begin
            if (i == tok.size() - 1) push_byte(tok[i], $urandom_range(99) < 8);
            else push_byte(tok[i], $urandom_range(99) < 3);
         end
         total += tok.size();
      end
   endtask

   initial begin : run_stimulus
      int base;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass, umlaut expansion on
      send_idle_pct = 14;
      recv_idle_pct = 55;
      set_strip_mode(1'b0);
      // ascii edges and case folding
      push_byte(8'h41, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h00, 1'b0);
      // two-letter umlaut, then sharp s closing a string
      push_byte(ulfa_pkg::LEAD_C3, 1'b0);
      push_byte(8'h84, 1'b0);
      push_byte(ulfa_pkg::LEAD_C3, 1'b0);
      push_byte(8'h9F, 1'b1);
      // empty table entry gives no character
      push_byte(ulfa_pkg::LEAD_C3, 1'b0);
      push_byte(8'h97, 1'b0);
      // ij ligature on page c4, and the top of page c5
      push_byte(ulfa_pkg::LEAD_C4, 1'b0);
      push_byte(8'hB2, 1'b1);
      push_byte(ulfa_pkg::LEAD_C5, 1'b0);
      push_byte(8'hBF, 1'b0);
      // lead byte followed by plain ascii, that byte is swallowed
      push_byte(ulfa_pkg::LEAD_C3, 1'b0);
      push_byte(8'h41, 1'b0);
      // two-, three- and four-byte sequences dropped by length code
      push_byte(8'hC2, 1'b0);
      push_byte(8'hA9, 1'b0);
      push_byte(8'hE2, 1'b0);
      push_byte(8'h82, 1'b0);
      push_byte(8'hAC, 1'b0);
      push_byte(8'hF0, 1'b0);
      push_byte(8'h9F, 1'b0);
      push_byte(8'h98, 1'b0);
      push_byte(8'h80, 1'b0);
      // stray bytes, then strings cut inside a skip and after a lead
      push_byte(8'h80, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'hE2, 1'b1);
      push_byte(ulfa_pkg::LEAD_C5, 1'b1);
      wait_drained();

      // plain stripping, sender mostly busy, receiver often stalled
      set_strip_mode(1'b1);
      queue_random_text(PHASE_BYTES);
      wait_drained();

      // expansion again, sender often idle, receiver mostly ready
      send_idle_pct = 55;
      recv_idle_pct = 14;
      set_strip_mode(1'b0);
      queue_random_text(PHASE_BYTES);
      wait_drained();

      // no idling at all, with long receiver hold-offs so the input backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_strip_mode(1'b1);
      queue_random_text(PHASE_BYTES);
      base = bytes_taken;
      while (bytes_taken < base + 10) @(posedge clock);
      holds_asked <= holds_asked + 1;
      while (bytes_taken < base + 70 && byte_feed.size() != 0) @(posedge clock);
      holds_asked <= holds_asked + 1;
      wait_drained();

      $display("run covered %0d input bytes and %0d result beats in both fold modes",
               bytes_taken, beats_seen);
      $display("pacing: sender-heavy, receiver-heavy, back to back, %0d receiver hold-offs",
               holds_done);
      if (fail_count == 0 && fold_expect.size() == 0) begin
         $display("utf8_latin_fold_to_ascii_core regression: pass");
      end else begin
         $display("utf8_latin_fold_to_ascii_core regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ulfa_pkg.sv
hw/rtl/ulfa_front.sv
hw/rtl/ulfa_queue.sv
hw/rtl/ulfa_back.sv
hw/rtl/utf8_latin_fold_to_ascii_core.sv
tb/sv/tb.sv
